[design/jsu_pkg.sv]
//------------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescape core: scanner
// phases, result kinds, error codes, scanner state and the result bundle.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

    // store size; the decoded length saturates here
    localparam int MAX_STRING_BYTES = 4096;
    localparam int LEN_W            = 13;
    localparam int MAX_RESULTS      = 3;
    localparam int CNT_W            = 2;

    // scanner phase
    typedef enum logic [1:0] {
        PH_WAIT,
        PH_STRING,
        PH_ESCAPE,
        PH_HEX
    } phase_t;

    // result kind
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_BYTE  = 2'd0;
    localparam kind_t KIND_END   = 2'd1;
    localparam kind_t KIND_ERROR = 2'd2;

    // error codes
    typedef logic [2:0] err_t;
    localparam err_t ERR_NONE   = 3'd0;
    localparam err_t ERR_OPEN   = 3'd1;
    localparam err_t ERR_ESCAPE = 3'd2;
    localparam err_t ERR_HEX    = 3'd3;
    localparam err_t ERR_ENDED  = 3'd4;

    typedef logic [LEN_W-1:0] len_t;

    // scanner state carried between transactions
    typedef struct packed {
        phase_t      phase;
        logic [1:0]  hex_seen;
        logic [15:0] code_point;
        len_t        length;
    } scan_state_t;

    // all results caused by one input transaction, entry 0 goes out first
    typedef struct packed {
        logic [CNT_W-1:0]                count;
        kind_t                           kind;
        err_t                            err;
        logic [MAX_RESULTS-1:0][7:0]     bytes;
        logic [MAX_RESULTS-1:0][LEN_W-1:0] lens;
    } result_bundle_t;

endpackage

`default_nettype wire

[design/jsu_decode.sv]
//------------------------------------------------------------------------------
// jsu_decode
// Combinational scanner step: from the current state and one text byte,
// works out the next state and the bundle of up to three results.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jsu_decode (
    input  wire jsu_pkg::scan_state_t    state_i,
    input  wire logic [7:0]              in_byte_i,
    input  wire logic                    end_of_data_i,
    output jsu_pkg::scan_state_t         state_next_o,
    output jsu_pkg::result_bundle_t      bundle_o
);
    import jsu_pkg::*;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_U     = 8'h75;

    // {valid, value} of a standard escape letter
    function automatic logic [8:0] esc_decode(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h22:   r = {1'b1, 8'h22};
            8'h5C:   r = {1'b1, 8'h5C};
            8'h2F:   r = {1'b1, 8'h2F};
            8'h62:   r = {1'b1, 8'h08};
            8'h66:   r = {1'b1, 8'h0C};
            8'h6E:   r = {1'b1, 8'h0A};
            8'h72:   r = {1'b1, 8'h0D};
            8'h74:   r = {1'b1, 8'h09};
            default: r = 9'h000;
        endcase
        return r;
    endfunction

    // {valid, value} of a hex digit, either case
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else begin
            r = 5'h00;
        end
        return r;
    endfunction

    // saturating length add
    function automatic len_t sat_add(input len_t base, input logic [1:0] inc);
        logic [LEN_W:0] sum;
        sum = {1'b0, base} + {{(LEN_W-1){1'b0}}, inc};
        if (sum > (LEN_W+1)'(MAX_STRING_BYTES)) begin
            return LEN_W'(MAX_STRING_BYTES);
        end
        return sum[LEN_W-1:0];
    endfunction

    logic        is_space;
    logic [8:0]  esc;
    logic [4:0]  hex;
    logic [15:0] cp_full;
    len_t        len_p1;
    len_t        len_p2;
    len_t        len_p3;

    // byte classification and code point assembly
    always_comb begin
        is_space = (in_byte_i == CH_SPACE) || (in_byte_i == CH_TAB) ||
                   (in_byte_i == CH_CR)    || (in_byte_i == CH_LF);
        esc      = esc_decode(in_byte_i);
        hex      = hex_decode(in_byte_i);
        cp_full  = {state_i.code_point[11:0], hex[3:0]};
        len_p1   = sat_add(state_i.length, 2'd1);
        len_p2   = sat_add(state_i.length, 2'd2);
        len_p3   = sat_add(state_i.length, 2'd3);
    end

    // next state
    always_comb begin
        state_next_o = state_i;
        if (end_of_data_i) begin
            if (state_i.phase != PH_WAIT) begin
                state_next_o.phase      = PH_WAIT;
                state_next_o.hex_seen   = 2'd0;
                state_next_o.code_point = 16'd0;
            end
        end else begin
            unique case (state_i.phase)
                PH_WAIT: begin
                    if (in_byte_i == CH_QUOTE) begin
                        state_next_o.phase  = PH_STRING;
                        state_next_o.length = '0;
                    end else if (!is_space) begin
                        state_next_o.hex_seen   = 2'd0;
                        state_next_o.code_point = 16'd0;
                    end
                end
                PH_STRING: begin
                    if (in_byte_i == CH_QUOTE) begin
                        state_next_o.phase = PH_WAIT;
                    end else if (in_byte_i == CH_BSL) begin
                        state_next_o.phase = PH_ESCAPE;
                    end else begin
                        state_next_o.length = len_p1;
                    end
                end
                PH_ESCAPE: begin
                    if (in_byte_i == CH_U) begin
                        state_next_o.phase      = PH_HEX;
                        state_next_o.hex_seen   = 2'd0;
                        state_next_o.code_point = 16'd0;
                    end else if (esc[8]) begin
                        state_next_o.phase  = PH_STRING;
                        state_next_o.length = len_p1;
                    end else begin
                        state_next_o.phase      = PH_WAIT;
                        state_next_o.hex_seen   = 2'd0;
                        state_next_o.code_point = 16'd0;
                    end
                end
                PH_HEX: begin
                    if (!hex[4]) begin
                        state_next_o.phase      = PH_WAIT;
                        state_next_o.hex_seen   = 2'd0;
                        state_next_o.code_point = 16'd0;
                    end else if (state_i.hex_seen == 2'd3) begin
                        state_next_o.phase      = PH_STRING;
                        state_next_o.hex_seen   = 2'd0;
                        state_next_o.code_point = 16'd0;
                        if (cp_full <= 16'h007F) begin
                            state_next_o.length = len_p1;
                        end else if (cp_full <= 16'h07FF) begin
                            state_next_o.length = len_p2;
                        end else begin
                            state_next_o.length = len_p3;
                        end
                    end else begin
                        state_next_o.code_point = cp_full;
                        state_next_o.hex_seen   = state_i.hex_seen + 2'd1;
                    end
                end
                default: state_next_o = state_i;
            endcase
        end
    end

    // result bundle
    always_comb begin
        bundle_o      = '0;
        bundle_o.kind = KIND_BYTE;
        bundle_o.err  = ERR_NONE;
        if (end_of_data_i) begin
            if (state_i.phase != PH_WAIT) begin
                bundle_o.count   = 2'd1;
                bundle_o.kind    = KIND_ERROR;
                bundle_o.err     = ERR_ENDED;
                bundle_o.lens[0] = state_i.length;
            end
        end else begin
            unique case (state_i.phase)
                PH_WAIT: begin
                    if (in_byte_i != CH_QUOTE && !is_space) begin
                        bundle_o.count = 2'd1;
                        bundle_o.kind  = KIND_ERROR;
                        bundle_o.err   = ERR_OPEN;
                    end
                end
                PH_STRING: begin
                    if (in_byte_i == CH_QUOTE) begin
                        bundle_o.count   = 2'd1;
                        bundle_o.kind    = KIND_END;
                        bundle_o.lens[0] = state_i.length;
                    end else if (in_byte_i != CH_BSL) begin
                        bundle_o.count    = 2'd1;
                        bundle_o.bytes[0] = in_byte_i;
                        bundle_o.lens[0]  = len_p1;
                    end
                end
                PH_ESCAPE: begin
                    if (in_byte_i == CH_U) begin
                        bundle_o.count = 2'd0;
                    end else if (esc[8]) begin
                        bundle_o.count    = 2'd1;
                        bundle_o.bytes[0] = esc[7:0];
                        bundle_o.lens[0]  = len_p1;
                    end else begin
                        bundle_o.count   = 2'd1;
                        bundle_o.kind    = KIND_ERROR;
                        bundle_o.err     = ERR_ESCAPE;
                        bundle_o.lens[0] = state_i.length;
                    end
                end
                PH_HEX: begin
                    if (!hex[4]) begin
                        bundle_o.count   = 2'd1;
                        bundle_o.kind    = KIND_ERROR;
                        bundle_o.err     = ERR_HEX;
                        bundle_o.lens[0] = state_i.length;
                    end else if (state_i.hex_seen == 2'd3) begin
                        bundle_o.lens[0] = len_p1;
                        bundle_o.lens[1] = len_p2;
                        bundle_o.lens[2] = len_p3;
                        if (cp_full <= 16'h007F) begin
                            bundle_o.count    = 2'd1;
                            bundle_o.bytes[0] = {1'b0, cp_full[6:0]};
                        end else if (cp_full <= 16'h07FF) begin
                            // two-byte utf-8
                            bundle_o.count    = 2'd2;
                            bundle_o.bytes[0] = {3'b110, cp_full[10:6]};
                            bundle_o.bytes[1] = {2'b10, cp_full[5:0]};
                        end else begin
                            // three-byte utf-8
                            bundle_o.count    = 2'd3;
                            bundle_o.bytes[0] = {4'b1110, cp_full[15:12]};
                            bundle_o.bytes[1] = {2'b10, cp_full[11:6]};
                            bundle_o.bytes[2] = {2'b10, cp_full[5:0]};
                        end
                    end
                end
                default: bundle_o = '0;
            endcase
        end
    end

endmodule

`default_nettype wire

[design/jsu_out.sv]
//------------------------------------------------------------------------------
// jsu_out
// Result register: holds the bundle of one input transaction and hands its
// entries out one per result transaction, flagging the final one.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jsu_out (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    load_i,
    input  wire jsu_pkg::result_bundle_t bundle_i,
    output logic                         space_o,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output jsu_pkg::kind_t               m_kind,
    output logic [7:0]                   m_out_byte,
    output jsu_pkg::len_t                m_decoded_length,
    output jsu_pkg::err_t                m_error_code,
    output logic                         m_last
);
    import jsu_pkg::*;

    logic [CNT_W-1:0]                  cnt_reg;
    logic [CNT_W-1:0]                  cnt_next;
    kind_t                             kind_reg;
    err_t                              err_reg;
    logic [MAX_RESULTS-1:0][7:0]       bytes_reg;
    logic [MAX_RESULTS-1:0][LEN_W-1:0] lens_reg;
    logic                              take;

    assign take    = m_valid && m_ready;
    assign space_o = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && m_ready);

    // remaining result count
    always_comb begin
        cnt_next = cnt_reg;
        if (load_i) begin
            cnt_next = bundle_i.count;
        end else if (take) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // payload: load a new bundle or shift the next entry to the front
    always_ff @(posedge aclk) begin
        if (load_i) begin
            kind_reg  <= bundle_i.kind;
            err_reg   <= bundle_i.err;
            bytes_reg <= bundle_i.bytes;
            lens_reg  <= bundle_i.lens;
        end else if (take) begin
            bytes_reg <= {8'd0, bytes_reg[MAX_RESULTS-1:1]};
            lens_reg  <= {{LEN_W{1'b0}}, lens_reg[MAX_RESULTS-1:1]};
        end
    end

    assign m_valid          = (cnt_reg != '0);
    assign m_kind           = kind_reg;
    assign m_error_code     = err_reg;
    assign m_out_byte       = bytes_reg[0];
    assign m_decoded_length = lens_reg[0];
    assign m_last           = (cnt_reg == CNT_W'(1));

endmodule

`default_nettype wire

[design/json_string_unescape_core.sv]
//------------------------------------------------------------------------------
// json_string_unescape_core
// Streaming JSON string unescaper: one text byte in, decoded string bytes,
// string-end and error results out.
//------------------------------------------------------------------------------
// One text byte is taken per cycle while s_ready is high. Whitespace or end of
// data before a string, the opening quote, a backslash, the u of a \u escape
// and the first three hex digits of a \u escape give no result; every other
// byte gives one result, and the fourth hex digit of a \u escape gives one to
// three UTF-8 bytes. A byte is decoded in the cycle it is taken and its
// results wait in a result register, which sends one result per cycle while
// m_ready is high; the next text byte is taken in the same cycle as the final
// result of the previous one leaves. The decoded length saturates at 4096. No
// surrogate pairing is done.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_core (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic [7:0]     s_in_byte,
    input  wire logic           s_end_of_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output jsu_pkg::kind_t      m_kind,
    output logic [7:0]          m_out_byte,
    output jsu_pkg::len_t       m_decoded_length,
    output jsu_pkg::err_t       m_error_code,
    output logic                m_last
);
    import jsu_pkg::*;

    scan_state_t    state_reg;
    scan_state_t    state_next;
    result_bundle_t bundle;
    logic           accept;

    assign accept = s_valid && s_ready;

    // scanner step
    jsu_decode u_decode (
        .state_i       (state_reg),
        .in_byte_i     (s_in_byte),
        .end_of_data_i (s_end_of_data),
        .state_next_o  (state_next),
        .bundle_o      (bundle)
    );

    // scanner state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase      <= PH_WAIT;
            state_reg.hex_seen   <= 2'd0;
            state_reg.code_point <= 16'd0;
            state_reg.length     <= '0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // result register and serialiser
    jsu_out u_out (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .load_i           (accept),
        .bundle_i         (bundle),
        .space_o          (s_ready),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_out_byte       (m_out_byte),
        .m_decoded_length (m_decoded_length),
        .m_error_code     (m_error_code),
        .m_last           (m_last)
    );

endmodule

`default_nettype wire

[dv/json_string_unescape_core_tb.sv]
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// json_string_unescape_core_tb
// Self-checking bench for the streaming JSON string unescaper. A directed
// table covers the extremes and each error path. One long string drives the
// decoded length into saturation. Random traffic follows: mostly well-formed
// strings with plain bytes, short escapes and \u escapes, and a share of
// noise and broken strings. It runs under sender gaps and receiver stalls.
// Every result transaction is checked field by field against an in-bench
// model of the scanner, or against the table for typed directed rows.
//------------------------------------------------------------------------------

module json_string_unescape_core_tb;
    import jsu_pkg::*;

    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int DRAIN_LIMIT      = 20_000;
    localparam int SATURATE_RUN     = MAX_STRING_BYTES + 8;
    localparam int RANDOM_PER_PHASE = 75;
    localparam int MAX_PRINTS       = 60;
    localparam int DIR_ROWS         = 29;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = "u";

    // one decoded result as seen on the m_ side
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        len_t        len;
        err_t        err;
        logic        last;
    } unesc_result_t;

    // one row of the directed table
    typedef struct packed {
        logic [7:0]    text;
        logic          eod;
        logic          typed;
        logic          has_result;
        unesc_result_t res;
    } dir_row_t;

    logic       aclk;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte     = 8'h00;
    logic       s_end_of_data = 1'b0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    kind_t      m_kind;
    logic [7:0] m_out_byte;
    len_t       m_decoded_length;
    err_t       m_error_code;
    logic       m_last;

    // scanner model state
    phase_t      scan_phase = PH_WAIT;
    logic [1:0]  hex_seen   = '0;
    logic [15:0] code_acc   = '0;
    len_t        str_len    = '0;

    unesc_result_t unescaped_q [$];
    dir_row_t      dir_table [DIR_ROWS];

    int fail_count     = 0;
    int cycle_count    = 0;
    int counted_items  = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    json_string_unescape_core DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_in_byte        (s_in_byte),
        .s_end_of_data    (s_end_of_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_out_byte       (m_out_byte),
        .m_decoded_length (m_decoded_length),
        .m_error_code     (m_error_code),
        .m_last           (m_last)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        if (fail_count <= MAX_PRINTS)
            $display("[%0t] mismatch on %0s: got 0x%0h, wanted 0x%0h", $time, what, got, want);
    endtask

    //--------------------------------------------------------------------------
    // scanner model
    //--------------------------------------------------------------------------

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
    endfunction

    // decoded value of a short escape letter, bit 8 set when not an escape
    function automatic logic [8:0] escape_byte(input logic [7:0] c);
        case (c)
            CH_QUOTE:  return {1'b0, CH_QUOTE};
            CH_BSLASH: return {1'b0, CH_BSLASH};
            "/":       return 9'h02F;
            "b":       return 9'h008;
            "f":       return 9'h00C;
            "n":       return 9'h00A;
            "r":       return 9'h00D;
            "t":       return 9'h009;
            default:   return 9'h100;
        endcase
    endfunction

    // hex digit value, bit 4 set when not a hex digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return {1'b0, c[3:0]};
        if (c >= "a" && c <= "f")
            return {1'b0, 4'(c - "a" + 8'd10)};
        if (c >= "A" && c <= "F")
            return {1'b0, 4'(c - "A" + 8'd10)};
        return 5'h10;
    endfunction

    function automatic void push_result(input kind_t k, input logic [7:0] d, input len_t l,
                                        input err_t e);
        unesc_result_t r;
        r.kind = k;
        r.data = d;
        r.len  = l;
        r.err  = e;
        r.last = 1'b0;
        unescaped_q.push_back(r);
    endfunction

    // one decoded string byte, length saturating at the store size
    function automatic void push_decoded(input logic [7:0] d);
        if (str_len < len_t'(MAX_STRING_BYTES))
            str_len = str_len + len_t'(1);
        push_result(KIND_BYTE, d, str_len, ERR_NONE);
    endfunction

    function automatic void push_error(input err_t e, input len_t l);
        scan_phase = PH_WAIT;
        hex_seen   = '0;
        code_acc   = '0;
        push_result(KIND_ERROR, 8'h00, l, e);
    endfunction

    // advance the scanner by one text byte and queue the results it gives
    function automatic void unescape_step(input logic [7:0] c, input logic eod);
        int            n_before;
        logic [8:0]    esc;
        logic [4:0]    nib;
        logic [15:0]   cp;
        unesc_result_t tail;
        n_before = unescaped_q.size();
        if (eod) begin
            if (scan_phase != PH_WAIT)
                push_error(ERR_ENDED, str_len);
        end else begin
            case (scan_phase)
                PH_WAIT: begin
                    if (c == CH_QUOTE) begin
                        scan_phase = PH_STRING;
                        str_len    = '0;
                    end else if (!is_blank(c)) begin
                        push_error(ERR_OPEN, '0);
                    end
                end
                PH_STRING: begin
                    if (c == CH_QUOTE) begin
                        scan_phase = PH_WAIT;
                        push_result(KIND_END, 8'h00, str_len, ERR_NONE);
                    end else if (c == CH_BSLASH) begin
                        scan_phase = PH_ESCAPE;
                    end else begin
                        push_decoded(c);
                    end
                end
                PH_ESCAPE: begin
                    esc = escape_byte(c);
                    if (c == CH_U) begin
                        scan_phase = PH_HEX;
                        hex_seen   = '0;
                        code_acc   = '0;
                    end else if (!esc[8]) begin
                        scan_phase = PH_STRING;
                        push_decoded(esc[7:0]);
                    end else begin
                        push_error(ERR_ESCAPE, str_len);
                    end
                end
                default: begin
                    nib = hex_nibble(c);
                    if (nib[4]) begin
                        push_error(ERR_HEX, str_len);
                    end else begin
                        cp = {code_acc[11:0], nib[3:0]};
                        if (hex_seen == 2'd3) begin
                            hex_seen   = '0;
                            code_acc   = '0;
                            scan_phase = PH_STRING;
                            // utf-8 encoding of the code point, no surrogate pairing
                            if (cp <= 16'h007F) begin
                                push_decoded(cp[7:0]);
                            end else if (cp <= 16'h07FF) begin
                                push_decoded({3'b110, cp[10:6]});
                                push_decoded({2'b10, cp[5:0]});
                            end else begin
                                push_decoded({4'b1110, cp[15:12]});
                                push_decoded({2'b10, cp[11:6]});
                                push_decoded({2'b10, cp[5:0]});
                            end
                        end else begin
                            code_acc = cp;
                            hex_seen = hex_seen + 2'd1;
                        end
                    end
                end
            endcase
        end
        // flag the final result of this byte
        if (unescaped_q.size() > n_before) begin
            tail = unescaped_q.pop_back();
            tail.last = 1'b1;
            unescaped_q.push_back(tail);
        end
    endfunction

    //--------------------------------------------------------------------------
    // input side
    //--------------------------------------------------------------------------

    // one input transaction, returns once it has been taken
    task automatic offer_byte(input logic [7:0] c, input logic eod);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_in_byte     <= c;
        s_end_of_data <= eod;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        // bytes the scanner merely skips are not counted
        if (!(scan_phase == PH_WAIT && (eod || is_blank(c))))
            counted_items++;
    endtask

    task automatic feed_byte(input logic [7:0] c, input logic eod);
        offer_byte(c, eod);
        unescape_step(c, eod);
    endtask

    // directed table builders
    function automatic dir_row_t silent_row(input logic [7:0] c, input logic eod);
        dir_row_t row;
        row            = '0;
        row.text       = c;
        row.eod        = eod;
        row.typed      = 1'b1;
        row.has_result = 1'b0;
        return row;
    endfunction

    function automatic dir_row_t typed_row(input logic [7:0] c, input logic eod, input kind_t k,
                                           input logic [7:0] d, input len_t l, input err_t e);
        dir_row_t row;
        row            = '0;
        row.text       = c;
        row.eod        = eod;
        row.typed      = 1'b1;
        row.has_result = 1'b1;
        row.res.kind   = k;
        row.res.data   = d;
        row.res.len    = l;
        row.res.err    = e;
        row.res.last   = 1'b1;
        return row;
    endfunction

    function automatic dir_row_t predicted_row(input logic [7:0] c, input logic eod);
        dir_row_t row;
        row      = '0;
        row.text = c;
        row.eod  = eod;
        return row;
    endfunction

    task automatic run_directed();
        int n_before;
        foreach (dir_table[i]) begin
            offer_byte(dir_table[i].text, dir_table[i].eod);
            n_before = unescaped_q.size();
            unescape_step(dir_table[i].text, dir_table[i].eod);
            // typed rows replace what the model queued with the value from the table
            if (dir_table[i].typed) begin
                while (unescaped_q.size() > n_before)
                    void'(unescaped_q.pop_back());
                if (dir_table[i].has_result)
                    unescaped_q.push_back(dir_table[i].res);
            end
        end
    endtask

    // random character pickers
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (c == CH_QUOTE || c == CH_BSLASH);
        return c;
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(3))
            0:       return 8'h20;
            1:       return 8'h09;
            2:       return 8'h0D;
            default: return 8'h0A;
        endcase
    endfunction

    function automatic logic [7:0] good_escape_letter();
        case ($urandom_range(7))
            0:       return CH_QUOTE;
            1:       return CH_BSLASH;
            2:       return "/";
            3:       return "b";
            4:       return "f";
            5:       return "n";
            6:       return "r";
            default: return "t";
        endcase
    endfunction

    function automatic logic [7:0] bad_escape_letter();
        logic [7:0] c;
        logic [8:0] esc;
        do begin
            c   = 8'($urandom_range(255));
            esc = escape_byte(c);
        end while (!esc[8] || c == CH_U);
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
            return 8'h30 + 8'(v);
        return 8'(($urandom_range(1) != 0 ? 8'h61 : 8'h41) + 8'(v) - 8'd10);
    endfunction

    function automatic logic [7:0] bad_hex_char();
        logic [7:0] c;
        logic [4:0] nib;
        do begin
            c   = 8'($urandom_range(255));
            nib = hex_nibble(c);
        end while (!nib[4]);
        return c;
    endfunction

    // one piece of string content: plain byte, short escape or \u escape
    task automatic send_token();
        int          pick;
        int          i;
        logic [15:0] cp;
        pick = $urandom_range(99);
        if (pick < 55) begin
            feed_byte(plain_char(), 1'b0);
        end else if (pick < 75) begin
            feed_byte(CH_BSLASH, 1'b0);
            feed_byte(good_escape_letter(), 1'b0);
        end else begin
            case ($urandom_range(3))
                0:       cp = 16'($urandom_range(16'h007F));
                1:       cp = 16'($urandom_range(16'h07FF, 16'h0080));
                default: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
            endcase
            feed_byte(CH_BSLASH, 1'b0);
            feed_byte(CH_U, 1'b0);
            for (i = 3; i >= 0; i--)
                feed_byte(hex_char(cp[4*i +: 4]), 1'b0);
        end
    endtask

    task automatic random_traffic(input int n);
        int goal;
        int pick;
        int k;
        goal = counted_items + n;
        while (counted_items < goal) begin
            pick = $urandom_range(99);
            if (pick < 72) begin
                // well-formed string with random content
                for (k = $urandom_range(2); k > 0; k--)
                    feed_byte(blank_char(), 1'b0);
                feed_byte(CH_QUOTE, 1'b0);
                for (k = $urandom_range(10); k > 0; k--)
                    send_token();
                feed_byte(CH_QUOTE, 1'b0);
            end else if (pick < 82) begin
                // noise byte, possibly an end of data
                feed_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
            end else begin
                // string broken off in one of several ways
                feed_byte(CH_QUOTE, 1'b0);
                for (k = $urandom_range(4); k > 0; k--)
                    send_token();
                case ($urandom_range(4))
                    0: begin
                        feed_byte(CH_BSLASH, 1'b0);
                        feed_byte(bad_escape_letter(), 1'b0);
                    end
                    1: begin
                        feed_byte(CH_BSLASH, 1'b0);
                        feed_byte(CH_U, 1'b0);
                        for (k = $urandom_range(3); k > 0; k--)
                            feed_byte(hex_char(4'($urandom_range(15))), 1'b0);
                        feed_byte(bad_hex_char(), 1'b0);
                    end
                    2: begin
                        feed_byte(8'($urandom_range(255)), 1'b1);
                    end
                    3: begin
                        feed_byte(CH_BSLASH, 1'b0);
                        feed_byte(8'($urandom_range(255)), 1'b1);
                    end
                    default: begin
                        feed_byte(CH_BSLASH, 1'b0);
                        feed_byte(CH_U, 1'b0);
                        for (k = $urandom_range(3); k > 0; k--)
                            feed_byte(hex_char(4'($urandom_range(15))), 1'b0);
                        feed_byte(8'($urandom_range(255)), 1'b1);
                    end
                endcase
            end
        end
    endtask

    // a string longer than the store, so the length saturates
    task automatic long_string();
        int k;
        feed_byte(CH_QUOTE, 1'b0);
        for (k = 0; k < SATURATE_RUN; k++)
            feed_byte(plain_char(), 1'b0);
        feed_byte(CH_QUOTE, 1'b0);
    endtask

    //--------------------------------------------------------------------------
    // result side
    //--------------------------------------------------------------------------

    // receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // compare each result transaction with the oldest pending one
    always @(posedge aclk) begin
        unesc_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (unescaped_q.size() == 0) begin
                report_mismatch("result with nothing pending", int'(m_kind), 0);
            end else begin
                want = unescaped_q.pop_front();
                if (m_kind !== want.kind)
                    report_mismatch("kind", int'(m_kind), int'(want.kind));
                if (m_out_byte !== want.data)
                    report_mismatch("out_byte", int'(m_out_byte), int'(want.data));
                if (m_decoded_length !== want.len)
                    report_mismatch("decoded_length", int'(m_decoded_length),
                                    int'(want.len));
                if (m_error_code !== want.err)
                    report_mismatch("error_code", int'(m_error_code), int'(want.err));
                if (m_last !== want.last)
                    report_mismatch("last", int'(m_last), int'(want.last));
            end
        end
    end

    //--------------------------------------------------------------------------
    // stimulus
    //--------------------------------------------------------------------------

    initial begin
        int k;
        dir_table = '{
            // while waiting: a blank is skipped, a stray byte is an open error, end of data is skipped
            silent_row(8'h20, 1'b0),
            typed_row("x", 1'b0, KIND_ERROR, 8'h00, len_t'(0), ERR_OPEN),
            silent_row(8'hFF, 1'b1),
            // control byte and top byte pass through
            silent_row(CH_QUOTE, 1'b0),
            typed_row(8'h00, 1'b0, KIND_BYTE, 8'h00, len_t'(1), ERR_NONE),
            typed_row(8'hFF, 1'b0, KIND_BYTE, 8'hFF, len_t'(2), ERR_NONE),
            // escaped code point zero
            silent_row(CH_BSLASH, 1'b0),
            silent_row(CH_U, 1'b0),
            silent_row("0", 1'b0),
            silent_row("0", 1'b0),
            silent_row("0", 1'b0),
            typed_row("0", 1'b0, KIND_BYTE, 8'h00, len_t'(3), ERR_NONE),
            // largest code point, mixed case digits, three bytes out
            silent_row(CH_BSLASH, 1'b0),
            silent_row(CH_U, 1'b0),
            silent_row("f", 1'b0),
            silent_row("F", 1'b0),
            silent_row("F", 1'b0),
            predicted_row("F", 1'b0),
            typed_row(CH_QUOTE, 1'b0, KIND_END, 8'h00, len_t'(6), ERR_NONE),
            // unknown escape letter
            silent_row(CH_QUOTE, 1'b0),
            silent_row(CH_BSLASH, 1'b0),
            typed_row("q", 1'b0, KIND_ERROR, 8'h00, len_t'(0), ERR_ESCAPE),
            // non-hex byte in a \u escape
            silent_row(CH_QUOTE, 1'b0),
            silent_row(CH_BSLASH, 1'b0),
            silent_row(CH_U, 1'b0),
            typed_row("G", 1'b0, KIND_ERROR, 8'h00, len_t'(0), ERR_HEX),
            // data ends inside a string
            silent_row(CH_QUOTE, 1'b0),
            typed_row("a", 1'b0, KIND_BYTE, "a", len_t'(1), ERR_NONE),
            typed_row(8'h00, 1'b1, KIND_ERROR, 8'h00, len_t'(1), ERR_ENDED)
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        long_string();

        // traffic under each pattern of gaps and stalls
        random_traffic(RANDOM_PER_PHASE);
        send_idle_pct  = 67;
        random_traffic(RANDOM_PER_PHASE);
        send_idle_pct  = 0;
        recv_stall_pct = 67;
        random_traffic(RANDOM_PER_PHASE);
        send_idle_pct  = 35;
        recv_stall_pct = 35;
        random_traffic(RANDOM_PER_PHASE);
        s_valid <= 1'b0;

        // drain outstanding results
        for (k = 0; k < DRAIN_LIMIT && unescaped_q.size() != 0; k++)
            @(posedge aclk);
        if (unescaped_q.size() != 0)
            report_mismatch("results still pending", unescaped_q.size(), 0);
        repeat (16) @(posedge aclk);

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
